FILE: hw/rtl/fdr_pkg.sv
// ----------------------------------------------------------------------------
// fdr_pkg: shared types and constants
// Widths of the fixed-point datapath of the Fresnel reflectance core.
// ----------------------------------------------------------------------------
package fdr_pkg;

    localparam int COS_W   = 16;  // input cosine, signed
    localparam int ETA_W   = 15;  // refractive index, unsigned Q2.13
    localparam int C_W     = 17;  // |cos| in Q.16, 0..65536
    localparam int SQ_W    = 30;  // index squared
    localparam int CC_W    = 33;  // c squared, up to 2^32
    localparam int RAD_W   = 62;  // sqrt radicand
    localparam int ROOT_W  = 31;  // floor sqrt of radicand
    localparam int BBC_W   = 47;  // b*b*c
    localparam int AC_W    = 32;  // a*c
    localparam int AW_W    = 46;  // a*w
    localparam int PAR_W   = 48;  // parallel ratio operands
    localparam int PER_W   = 33;  // perpendicular ratio operands
    localparam int Q_FRAC  = 30;  // ratio fraction bits
    localparam int SUMSQ_W = 63;  // sum of two squared ratios plus rounding
    localparam int REF_W   = 16;  // reflectance, unsigned Q1.15
    localparam int REF_SH  = 46;  // Q0.60 to Q1.15

    localparam logic [REF_W-1:0] REF_FULL = 16'h8000;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ETA_INCIDENT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ETA_TRANSMITTED = 1'b1;

    // side data travelling alongside the square root
    typedef struct packed {
        logic [ETA_W-1:0] a;
        logic [BBC_W-1:0] bbc;
        logic [AC_W-1:0]  ac;
        logic             tir;
    } t_front_side;

endpackage

FILE: hw/rtl/fdr_front.sv
// ----------------------------------------------------------------------------
// fdr_front: cosine conditioning and radicand
// Saturates and folds the cosine, swaps indices, forms the index products,
// decides total internal reflection and builds the square-root radicand.
// Five register stages.
// ----------------------------------------------------------------------------
module fdr_front #(
    parameter int COS_FRAC_BITS = 14
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [fdr_pkg::COS_W-1:0]      i_cos,
    input  logic [fdr_pkg::ETA_W-1:0]      i_eta_inc,
    input  logic [fdr_pkg::ETA_W-1:0]      i_eta_trn,
    output logic                           o_valid,
    output logic [fdr_pkg::RAD_W-1:0]      o_rad,
    output fdr_pkg::t_front_side           o_side
);

    localparam logic signed [31:0] CosOne = 32'sd1 <<< COS_FRAC_BITS;

    // saturate, fold and swap
    logic signed [31:0] w_x;
    logic signed [31:0] w_sat;
    logic               w_pos;
    logic [31:0]        w_mag;
    logic [31:0]        w_c32;

    assign w_x   = 32'(signed'(i_cos));
    assign w_sat = (w_x > CosOne) ? CosOne : ((w_x < -CosOne) ? -CosOne : w_x);
    assign w_pos = (w_sat > 32'sd0);
    assign w_mag = w_pos ? 32'(w_sat) : 32'(-w_sat);

    generate
        if (COS_FRAC_BITS <= 16) begin : g_shl
            assign w_c32 = w_mag << (16 - COS_FRAC_BITS);
        end else begin : g_rnd
            assign w_c32 = (w_mag + (32'd1 << (COS_FRAC_BITS - 17))) >> (COS_FRAC_BITS - 16);
        end
    endgenerate

    // stage 1
    logic                        r1_v;
    logic [fdr_pkg::ETA_W-1:0]   r1_a, r1_b;
    logic [fdr_pkg::C_W-1:0]     r1_c;
    // stage 2
    logic                        r2_v;
    logic [fdr_pkg::SQ_W-1:0]    r2_aa, r2_bb;
    logic [fdr_pkg::CC_W-1:0]    r2_cc;
    logic [fdr_pkg::ETA_W-1:0]   r2_a;
    logic [fdr_pkg::C_W-1:0]     r2_c;
    // stage 3
    logic                        r3_v;
    logic [fdr_pkg::RAD_W-1:0]   r3_p;
    logic                        r3_cchi;
    logic [fdr_pkg::SQ_W-1:0]    r3_aa, r3_bb;
    logic [fdr_pkg::BBC_W-1:0]   r3_bbc;
    logic [fdr_pkg::AC_W-1:0]    r3_ac;
    logic [fdr_pkg::ETA_W-1:0]   r3_a;
    // stage 4
    logic                        r4_v;
    logic [fdr_pkg::RAD_W-1:0]   r4_lhs, r4_rhs;
    logic [fdr_pkg::BBC_W-1:0]   r4_bbc;
    logic [fdr_pkg::AC_W-1:0]    r4_ac;
    logic [fdr_pkg::ETA_W-1:0]   r4_a;
    // stage 5
    logic                        r5_v;
    logic [fdr_pkg::RAD_W-1:0]   r5_rad;
    fdr_pkg::t_front_side        r5_side;

    logic                        n_tir;

    assign n_tir = (r4_lhs >= r4_rhs);

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a <= w_pos ? i_eta_inc : i_eta_trn;
            r1_b <= w_pos ? i_eta_trn : i_eta_inc;
            r1_c <= w_c32[fdr_pkg::C_W-1:0];

            r2_aa <= fdr_pkg::SQ_W'(r1_a) * fdr_pkg::SQ_W'(r1_a);
            r2_bb <= fdr_pkg::SQ_W'(r1_b) * fdr_pkg::SQ_W'(r1_b);
            r2_cc <= fdr_pkg::CC_W'(fdr_pkg::CC_W'(r1_c) * fdr_pkg::CC_W'(r1_c));
            r2_a  <= r1_a;
            r2_c  <= r1_c;

            // a*a*c*c on the low 32 bits of c*c; top bit handled next stage
            r3_p    <= fdr_pkg::RAD_W'(fdr_pkg::RAD_W'(r2_aa) * fdr_pkg::RAD_W'(r2_cc[31:0]));
            r3_cchi <= r2_cc[32];
            r3_aa   <= r2_aa;
            r3_bb   <= r2_bb;
            r3_bbc  <= fdr_pkg::BBC_W'(fdr_pkg::BBC_W'(r2_bb) * fdr_pkg::BBC_W'(r2_c));
            r3_ac   <= fdr_pkg::AC_W'(fdr_pkg::AC_W'(r2_a) * fdr_pkg::AC_W'(r2_c));
            r3_a    <= r2_a;

            // a*a*(2^32 - c*c); zero at normal incidence, c = 1.0
            r4_lhs <= r3_cchi ? '0 : ({r3_aa, 32'd0} - r3_p);
            r4_rhs <= {r3_bb, 32'd0};
            r4_bbc <= r3_bbc;
            r4_ac  <= r3_ac;
            r4_a   <= r3_a;

            r5_rad       <= n_tir ? '0 : (r4_rhs - r4_lhs);
            r5_side.a    <= r4_a;
            r5_side.bbc  <= r4_bbc;
            r5_side.ac   <= r4_ac;
            r5_side.tir  <= n_tir;
        end
    end

    assign o_valid = r5_v;
    assign o_rad   = r5_rad;
    assign o_side  = r5_side;

endmodule

FILE: hw/rtl/fdr_sqrt.sv
// ----------------------------------------------------------------------------
// fdr_sqrt: pipelined integer square root
// Floor square root of a 62-bit radicand, one result bit per register stage,
// with side data carried alongside.
// ----------------------------------------------------------------------------
module fdr_sqrt #(
    parameter int SIDE_W = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [fdr_pkg::RAD_W-1:0]     i_rad,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_valid,
    output logic [fdr_pkg::ROOT_W-1:0]    o_root,
    output logic [SIDE_W-1:0]             o_side
);

    localparam int N = fdr_pkg::ROOT_W;

    logic                        w_v    [0:N];
    logic [fdr_pkg::RAD_W-1:0]   w_rem  [0:N];
    logic [N-1:0]                w_root [0:N];
    logic [SIDE_W-1:0]           w_side [0:N];

    assign w_v[0]    = i_valid;
    assign w_rem[0]  = i_rad;
    assign w_root[0] = '0;
    assign w_side[0] = i_side;

    genvar i;
    generate
        for (i = 0; i < N; i++) begin : g_step
            localparam int K = N - 1 - i;

            logic                       r_v;
            logic [fdr_pkg::RAD_W-1:0]  r_rem;
            logic [N-1:0]               r_root;
            logic [SIDE_W-1:0]          r_side;
            logic [63:0]                n_trial;
            logic                       n_ge;

            // trial = (root << (K+1)) + 4^K; low bits of root are still clear
            assign n_trial = (64'(w_root[i]) << (K + 1)) | (64'd1 << (2 * K));
            assign n_ge    = (64'(w_rem[i]) >= n_trial);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v <= 1'b0;
                end else if (i_en) begin
                    r_v <= w_v[i];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem  <= n_ge ? (w_rem[i] - n_trial[fdr_pkg::RAD_W-1:0]) : w_rem[i];
                    r_root <= n_ge ? (w_root[i] | (N'(1) << K)) : w_root[i];
                    r_side <= w_side[i];
                end
            end

            assign w_v[i+1]    = r_v;
            assign w_rem[i+1]  = r_rem;
            assign w_root[i+1] = r_root;
            assign w_side[i+1] = r_side;
        end
    endgenerate

    assign o_valid = w_v[N];
    assign o_root  = w_root[N];
    assign o_side  = w_side[N];

endmodule

FILE: hw/rtl/fdr_div.sv
// ----------------------------------------------------------------------------
// fdr_div: pipelined fractional divider
// floor(num * 2^30 / den) for num <= den, one quotient bit per stage.
// A zero denominator or num not below den gives exactly 1.0.
// ----------------------------------------------------------------------------
module fdr_div #(
    parameter int W      = 48,
    parameter int SIDE_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [W-1:0]                i_num,
    input  logic [W-1:0]                i_den,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [fdr_pkg::Q_FRAC:0]    o_ratio,
    output logic [SIDE_W-1:0]           o_side
);

    localparam int N = fdr_pkg::Q_FRAC;

    logic              w_v    [0:N];
    logic [W-1:0]      w_rem  [0:N];
    logic [W-1:0]      w_den  [0:N];
    logic [N-1:0]      w_q    [0:N];
    logic              w_one  [0:N];
    logic [SIDE_W-1:0] w_side [0:N];

    assign w_v[0]    = i_valid;
    assign w_rem[0]  = i_num;
    assign w_den[0]  = i_den;
    assign w_q[0]    = '0;
    assign w_one[0]  = (i_den == '0) || (i_num >= i_den);
    assign w_side[0] = i_side;

    genvar i;
    generate
        for (i = 0; i < N; i++) begin : g_step
            logic              r_v;
            logic [W-1:0]      r_rem;
            logic [W-1:0]      r_den;
            logic [N-1:0]      r_q;
            logic              r_one;
            logic [SIDE_W-1:0] r_side;
            logic [W:0]        n_sh;
            logic [W:0]        n_sub;
            logic              n_ge;

            // restoring step
            assign n_sh  = {w_rem[i], 1'b0};
            assign n_sub = n_sh - {1'b0, w_den[i]};
            assign n_ge  = (n_sh >= {1'b0, w_den[i]});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v <= 1'b0;
                end else if (i_en) begin
                    r_v <= w_v[i];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem  <= n_ge ? n_sub[W-1:0] : n_sh[W-1:0];
                    r_den  <= w_den[i];
                    r_q    <= {w_q[i][N-2:0], n_ge};
                    r_one  <= w_one[i];
                    r_side <= w_side[i];
                end
            end

            assign w_v[i+1]    = r_v;
            assign w_rem[i+1]  = r_rem;
            assign w_den[i+1]  = r_den;
            assign w_q[i+1]    = r_q;
            assign w_one[i+1]  = r_one;
            assign w_side[i+1] = r_side;
        end
    endgenerate

    assign o_valid = w_v[N];
    assign o_ratio = w_one[N] ? ((N+1)'(1) << N) : {1'b0, w_q[N]};
    assign o_side  = w_side[N];

endmodule

FILE: hw/rtl/fdr_ratio.sv
// ----------------------------------------------------------------------------
// fdr_ratio: amplitude ratios and reflectance
// From the transmitted-cosine root forms both amplitude ratios, divides them
// in two parallel lanes, squares, sums and rounds to Q1.15.
// ----------------------------------------------------------------------------
module fdr_ratio (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [fdr_pkg::ROOT_W-1:0]    i_root,
    input  fdr_pkg::t_front_side          i_side,
    output logic                          o_valid,
    output logic [fdr_pkg::REF_W-1:0]     o_refl,
    output logic                          o_tir
);

    // stage m1: a*w
    logic                          r1_v;
    logic [fdr_pkg::AW_W-1:0]      r1_aw;
    logic [fdr_pkg::BBC_W-1:0]     r1_bbc;
    logic [fdr_pkg::AC_W-1:0]      r1_ac;
    logic [fdr_pkg::ROOT_W-1:0]    r1_w;
    logic                          r1_tir;
    // stage m2: numerators and denominators
    logic                          r2_v;
    logic [fdr_pkg::PAR_W-1:0]     r2_npar, r2_dpar;
    logic [fdr_pkg::PER_W-1:0]     r2_nper, r2_dper;
    logic                          r2_tir;

    logic [fdr_pkg::PAR_W-1:0]     w_bbc, w_aw;
    logic [fdr_pkg::PER_W-1:0]     w_ac, w_w;

    assign w_bbc = fdr_pkg::PAR_W'(r1_bbc);
    assign w_aw  = fdr_pkg::PAR_W'(r1_aw);
    assign w_ac  = fdr_pkg::PER_W'(r1_ac);
    assign w_w   = fdr_pkg::PER_W'(r1_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_aw  <= fdr_pkg::AW_W'(fdr_pkg::AW_W'(i_side.a) * fdr_pkg::AW_W'(i_root));
            r1_bbc <= i_side.bbc;
            r1_ac  <= i_side.ac;
            r1_w   <= i_root;
            r1_tir <= i_side.tir;

            r2_npar <= (w_bbc >= w_aw) ? (w_bbc - w_aw) : (w_aw - w_bbc);
            r2_dpar <= w_bbc + w_aw;
            r2_nper <= (w_ac >= w_w) ? (w_ac - w_w) : (w_w - w_ac);
            r2_dper <= w_ac + w_w;
            r2_tir  <= r1_tir;
        end
    end

    // two divider lanes in lockstep
    logic                          w_par_v, w_per_v;
    logic [fdr_pkg::Q_FRAC:0]      w_rpar, w_rper;
    logic                          w_par_tir, w_per_tir;

    fdr_div #(.W(fdr_pkg::PAR_W), .SIDE_W(1)) u_div_par (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r2_v),
        .i_num   (r2_npar),
        .i_den   (r2_dpar),
        .i_side  (r2_tir),
        .o_valid (w_par_v),
        .o_ratio (w_rpar),
        .o_side  (w_par_tir)
    );

    fdr_div #(.W(fdr_pkg::PER_W), .SIDE_W(1)) u_div_per (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r2_v),
        .i_num   (r2_nper),
        .i_den   (r2_dper),
        .i_side  (r2_tir),
        .o_valid (w_per_v),
        .o_ratio (w_rper),
        .o_side  (w_per_tir)
    );

    // stage m3: squares; stage m4: sum and round
    logic                          r3_v;
    logic [fdr_pkg::SUMSQ_W-1:0]   r3_sqpar, r3_sqper;
    logic                          r3_tir;
    logic                          r4_v;
    logic [fdr_pkg::REF_W-1:0]     r4_refl;
    logic                          r4_tir;
    logic [fdr_pkg::SUMSQ_W-1:0]   n_sum;

    assign n_sum = r3_sqpar + r3_sqper + (fdr_pkg::SUMSQ_W'(1) << (fdr_pkg::REF_SH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= w_par_v & w_per_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_sqpar <= fdr_pkg::SUMSQ_W'(fdr_pkg::SUMSQ_W'(w_rpar) * fdr_pkg::SUMSQ_W'(w_rpar));
            r3_sqper <= fdr_pkg::SUMSQ_W'(fdr_pkg::SUMSQ_W'(w_rper) * fdr_pkg::SUMSQ_W'(w_rper));
            r3_tir   <= w_par_tir | w_per_tir;

            r4_refl <= r3_tir ? fdr_pkg::REF_FULL
                              : n_sum[fdr_pkg::REF_SH +: fdr_pkg::REF_W];
            r4_tir  <= r3_tir;
        end
    end

    assign o_valid = r4_v;
    assign o_refl  = r4_refl;
    assign o_tir   = r4_tir;

endmodule

FILE: hw/rtl/fresnel_dielectric_reflectance_core.sv
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance_core: unpolarised dielectric Fresnel term
// Takes a signed incidence cosine and returns the reflected fraction of a
// dielectric boundary, with a total-internal-reflection flag.
// ----------------------------------------------------------------------------
// Use:
//   Slave stream: s_tdata carries the cosine (signed, COS_FRAC_BITS fraction).
//   Master stream: m_tdata carries reflectance (Q1.15), m_tuser the flag.
//   Config channel: index 0 writes the incident index, index 1 the
//   transmitted index (Q2.13); always ready, write only while idle.
// Throughput: one item per cycle while the receiver keeps m_tready high.
// Pipeline: 71 register stages from the accepting edge until the item shows
//   on the master stream: the 31-stage square root, the 30-stage divider
//   lanes, nine arithmetic stages and the output register.
// Reset: both indices return to 1.0, all valid bits and the output clear.
// Stall: when the receiver holds m_tready low, a skid register absorbs the
//   item in flight; the pipeline then freezes and s_tready drops until the
//   skid drains. No item is lost or repeated.
// ----------------------------------------------------------------------------
module fresnel_dielectric_reflectance_core #(
    parameter int COS_FRAC_BITS = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fdr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fdr_pkg::ETA_W-1:0]         i_cfg_data,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [15:0]                       i_s_tdata,   // [15:0] cos_incidence
    // output stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [15:0]                       o_m_tdata,   // [15:0] reflectance
    output logic                              o_m_tuser    // [0] total_internal
);

    localparam logic [fdr_pkg::ETA_W-1:0] EtaReset = 15'd8192;

    // index registers
    logic [fdr_pkg::ETA_W-1:0] r_eta_inc, r_eta_trn;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta_inc <= EtaReset;
            r_eta_trn <= EtaReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fdr_pkg::REG_ETA_INCIDENT:    r_eta_inc <= i_cfg_data;
                fdr_pkg::REG_ETA_TRANSMITTED: r_eta_trn <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advances while the skid register is empty
    logic r_skid_v;
    logic w_en;

    assign w_en       = !r_skid_v;
    assign o_s_tready = w_en;

    logic                          w_f_v;
    logic [fdr_pkg::RAD_W-1:0]     w_rad;
    fdr_pkg::t_front_side          w_f_side;

    fdr_front #(.COS_FRAC_BITS(COS_FRAC_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_s_tvalid),
        .i_cos     (i_s_tdata),
        .i_eta_inc (r_eta_inc),
        .i_eta_trn (r_eta_trn),
        .o_valid   (w_f_v),
        .o_rad     (w_rad),
        .o_side    (w_f_side)
    );

    logic                          w_s_v;
    logic [fdr_pkg::ROOT_W-1:0]    w_root;
    fdr_pkg::t_front_side          w_s_side;

    fdr_sqrt #(.SIDE_W($bits(fdr_pkg::t_front_side))) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_v),
        .i_rad   (w_rad),
        .i_side  (w_f_side),
        .o_valid (w_s_v),
        .o_root  (w_root),
        .o_side  (w_s_side)
    );

    logic                          w_r_v;
    logic [fdr_pkg::REF_W-1:0]     w_refl;
    logic                          w_tir;

    fdr_ratio u_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_v),
        .i_root  (w_root),
        .i_side  (w_s_side),
        .o_valid (w_r_v),
        .o_refl  (w_refl),
        .o_tir   (w_tir)
    );

    // output register with skid
    logic                          r_out_v;
    logic [fdr_pkg::REF_W-1:0]     r_out_refl, r_skid_refl;
    logic                          r_out_tir, r_skid_tir;
    logic                          w_out_free;
    logic                          w_push;

    assign w_out_free = !r_out_v || i_m_tready;
    assign w_push     = w_en && w_r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_push) begin
                if (w_out_free) begin
                    r_out_v <= 1'b1;
                end else begin
                    r_skid_v <= 1'b1;
                end
            end else if (w_out_free) begin
                r_out_v  <= r_skid_v;
                r_skid_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            if (w_out_free) begin
                r_out_refl <= w_refl;
                r_out_tir  <= w_tir;
            end else begin
                r_skid_refl <= w_refl;
                r_skid_tir  <= w_tir;
            end
        end else if (w_out_free) begin
            r_out_refl <= r_skid_refl;
            r_out_tir  <= r_skid_tir;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_refl;
    assign o_m_tuser  = r_out_tir;

endmodule

FILE: dv/fresnel_dielectric_reflectance_core_test.sv
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance_core_test: self-checking bench
// Drives incidence cosines under several index settings, predicts the
// reflectance and the total-internal-reflection flag in exact integer
// arithmetic, and compares every output item in order. Both stream sides
// idle in random bursts; one long receiver hold fills the pipeline.
// ----------------------------------------------------------------------------
module fresnel_dielectric_reflectance_core_test;

    localparam int LATENCY   = 70;
    localparam int WDOG_MAX  = 20000;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [fdr_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [fdr_pkg::ETA_W-1:0]      i_cfg_data;
    logic                           i_s_tvalid;
    logic                           o_s_tready;
    logic [15:0]                    i_s_tdata;   // [15:0] cos_incidence
    logic                           o_m_tvalid;
    logic                           i_m_tready;
    logic [15:0]                    o_m_tdata;   // [15:0] reflectance
    logic                           o_m_tuser;   // [0] total_internal

    typedef struct packed {
        logic [15:0] refl;
        logic        tir;
    } t_refl_item;

    // predictor's own copy of the index registers
    logic [fdr_pkg::ETA_W-1:0] eta_in_q;
    logic [fdr_pkg::ETA_W-1:0] eta_out_q;

    t_refl_item  refl_expected[$];
    int          mismatches;
    int          refl_seen;
    int          tir_seen;
    int          wdog;
    bit          rx_idle_on;
    bit          rx_hold_req;
    int          rx_hold_cycles;

    fresnel_dielectric_reflectance_core dut (.*);

    // clock
    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // exact integer square root, floor
    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v  -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // floor(num * 2^30 / den); a zero denominator or num >= den saturates at one
    function automatic longint unsigned ratio_q30(input longint unsigned num,
                                                   input longint unsigned den);
        longint unsigned q, r;
        q = 0;
        r = num;
        if (den == 0 || num >= den) return 64'd1 << 30;
        for (int i = 0; i < 30; i++) begin
            r <<= 1;
            q <<= 1;
            if (r >= den) begin
                r -= den;
                q |= 1;
            end
        end
        return q;
    endfunction

    function automatic longint unsigned absdiff(input longint unsigned x,
                                                input longint unsigned y);
        return (x >= y) ? x - y : y - x;
    endfunction

    function automatic t_refl_item predict_reflectance(input logic [15:0] cos_raw);
        t_refl_item      r;
        longint          x;
        longint unsigned a, b, c, s2, lhs, rhs, w, bbc, aw, ac, rpar, rper, sum;
        x = longint'($signed(cos_raw));
        if (x > 16384)  x = 16384;
        if (x < -16384) x = -16384;
        // leaving the medium swaps the indices
        if (x > 0) begin
            a = eta_in_q;  b = eta_out_q;
        end else begin
            a = eta_out_q; b = eta_in_q;  x = -x;
        end
        c   = longint'(x) << 2;
        s2  = (64'd1 << 32) - c * c;
        lhs = a * a * s2;
        rhs = (b * b) << 32;
        if (lhs >= rhs) begin
            r.refl = fdr_pkg::REF_FULL;
            r.tir  = 1'b1;
            return r;
        end
        w    = isqrt(rhs - lhs);
        bbc  = b * b * c;
        aw   = a * w;
        ac   = a * c;
        rpar = ratio_q30(absdiff(bbc, aw), bbc + aw);
        rper = ratio_q30(absdiff(ac, w), ac + w);
        sum  = rpar * rpar + rper * rper;
        r.refl = 16'((sum + (64'd1 << 45)) >> 46);
        r.tir  = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // result checker and watchdog, sampled at the rising edge
    always @(posedge i_clk) begin
        t_refl_item want;
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (i_cfg_valid && o_cfg_ready) ||
                (o_m_tvalid && i_m_tready))
                wdog <= 0;
            else
                wdog <= wdog + 1;
            if (o_m_tvalid && i_m_tready) begin
                refl_seen++;
                if (refl_expected.size() == 0) begin
                    report_mismatch("unexpected item", o_m_tdata, -1);
                end else begin
                    want = refl_expected.pop_front();
                    if (o_m_tdata !== want.refl)
                        report_mismatch("reflectance", o_m_tdata, want.refl);
                    if (o_m_tuser !== want.tir)
                        report_mismatch("total_internal", o_m_tuser, want.tir);
                    if (want.tir) tir_seen++;
                end
            end
            if (wdog >= WDOG_MAX) begin
                $display("watchdog expired, %0d items outstanding", refl_expected.size());
                $display("fresnel_dielectric_reflectance_core_test: done, errors");
                $finish;
            end
        end
    end

    // receiver: random stalls, or a long counted hold on request
    initial begin
        int burst;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                i_m_tready = 1'b0;
                for (int k = 0; k < rx_hold_cycles; k++) @(negedge i_clk);
                rx_hold_req = 1'b0;
                i_m_tready  = 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                burst      = $urandom_range(1, 13);
                i_m_tready = 1'b0;
                for (int k = 1; k < burst; k++) @(negedge i_clk);
                i_m_tready = 1'b1;
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    // one cosine item, with an optional idle burst first
    task automatic send_cosine(input logic [15:0] cos_raw, input bit may_idle);
        if (may_idle && $urandom_range(0, 5) == 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = cos_raw;
        refl_expected.push_back(predict_reflectance(cos_raw));
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic drain_results();
        while (refl_expected.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
    endtask

    task automatic write_index(input logic [fdr_pkg::CFG_IDX_W-1:0] idx,
                               input logic [fdr_pkg::ETA_W-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == fdr_pkg::REG_ETA_INCIDENT) eta_in_q = val;
        else                                  eta_out_q = val;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_indices(input logic [fdr_pkg::ETA_W-1:0] n_in,
                               input logic [fdr_pkg::ETA_W-1:0] n_out);
        drain_results();
        write_index(fdr_pkg::REG_ETA_INCIDENT, n_in);
        write_index(fdr_pkg::REG_ETA_TRANSMITTED, n_out);
    endtask

    function automatic logic [15:0] random_cosine();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);                  // anything, saturates
            1:       return 16'($urandom_range(0, 64));     // near grazing
            2:       return 16'(-$urandom_range(0, 64));
            3:       return 16'($urandom_range(16320, 16384));
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    // extremes of the cosine, zero, saturation and grazing, at reset indices
    task automatic test_directed_cosines();
        logic [15:0] pts[] = '{16'h0000, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000,
                               16'h4001, 16'hBFFF, 16'h0001, 16'hFFFF, 16'h2000,
                               16'hE000, 16'h5555, 16'hAAAA, 16'h3FFF, 16'hC001};
        foreach (pts[i]) send_cosine(pts[i], 1'b0);
    endtask

    // dense to light, light to dense (total internal reflection when leaving)
    task automatic test_index_extremes();
        logic [fdr_pkg::ETA_W-1:0] pairs[7][2] = '{
            '{15'd8192, 15'd32767}, '{15'd32767, 15'd8192},
            '{15'd32767, 15'd32767}, '{15'd12288, 15'd10923},
            '{15'd0, 15'd8192}, '{15'd8192, 15'd0},
            '{15'd1, 15'd4096}};
        foreach (pairs[p]) begin
            set_indices(pairs[p][0], pairs[p][1]);
            send_cosine(16'h0000, 1'b0);
            send_cosine(16'h4000, 1'b0);
            send_cosine(16'hC000, 1'b0);
            send_cosine(16'h0001, 1'b0);
            send_cosine(16'hFFFF, 1'b0);
        end
    endtask

    // random cosines under random indices, with idling on both sides
    task automatic test_random_stream(input int n_items);
        rx_idle_on = 1'b1;
        for (int i = 0; i < n_items; i++) begin
            if (i % 150 == 0)
                set_indices(15'($urandom_range(8192, 32767)), 15'($urandom_range(8192, 32767)));
            send_cosine(random_cosine(), 1'b1);
        end
    endtask

    // long receiver hold while the sender keeps offering, then a full pause
    task automatic test_backpressure();
        rx_idle_on     = 1'b0;
        rx_hold_cycles = 400;
        rx_hold_req    = 1'b1;
        for (int i = 0; i < 200; i++) send_cosine(random_cosine(), 1'b0);
        drain_results();
        for (int i = 0; i < 100; i++) send_cosine(random_cosine(), 1'b0);
    endtask

    initial begin
        mismatches  = 0;
        refl_seen   = 0;
        tir_seen    = 0;
        wdog        = 0;
        rx_idle_on  = 1'b0;
        rx_hold_req = 1'b0;
        eta_in_q    = 15'd8192;
        eta_out_q   = 15'd8192;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = fdr_pkg::REG_ETA_INCIDENT;
        i_cfg_data  = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed_cosines();
        test_index_extremes();
        test_random_stream(700);
        test_backpressure();
        drain_results();

        $display("covered %0d reflectance items, %0d with total internal reflection,",
                 refl_seen, tir_seen);
        $display("over index extremes, random settings, idling and a long output hold");
        if (mismatches == 0 && refl_expected.size() == 0) begin
            $display("fresnel_dielectric_reflectance_core_test: done, clean");
        end else begin
            $display("fresnel_dielectric_reflectance_core_test: done, errors");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/fdr_pkg.sv
hw/rtl/fdr_front.sv
hw/rtl/fdr_sqrt.sv
hw/rtl/fdr_div.sv
hw/rtl/fdr_ratio.sv
hw/rtl/fresnel_dielectric_reflectance_core.sv
dv/fresnel_dielectric_reflectance_core_test.sv
